// ----- hw/rtl/json_key_value_extractor_assert.svh -----
// Assertion macros for the JSON key/value extractor modules.
// Used by files that check their own logic; expects clk and rst_n in scope.
`ifndef JSON_KEY_VALUE_EXTRACTOR_ASSERT_SVH
`define JSON_KEY_VALUE_EXTRACTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define JKV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jkv assertion failed");
`define JKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jkv assertion failed");
`else
`define JKV_ASSERT_SAME(lbl, ante, cons)
`define JKV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/jkv_pkg.sv -----
// Shared types, constants and helpers for the JSON key/value extractor.
// No dependencies.
`default_nettype none
package jkv_pkg;

  localparam int MAX_KEY_BYTES = 8;
  localparam int KEY_IDX_W     = 3;
  localparam int KEY_LEN_W     = 4;
  localparam int KEY_BITS      = 64;
  localparam int DEPTH_BITS    = 8;
  localparam int POS_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_COMMA     = 8'h2c;
  localparam logic [7:0] CH_LBRACE    = 8'h7b;
  localparam logic [7:0] CH_LBRACKET  = 8'h5b;
  localparam logic [7:0] CH_RBRACE    = 8'h7d;
  localparam logic [7:0] CH_RBRACKET  = 8'h5d;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] value_start;
    logic [POS_W-1:0] value_length;
  } out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key_bytes;
    logic [KEY_LEN_W-1:0] key_length;
  } key_cfg_t;

  typedef struct packed {
    logic emit;
    out_t res;
  } scan_res_t;

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/jkv_cfg.sv -----
// Key configuration registers of the JSON key/value extractor.
// Depends on jkv_pkg.
`default_nettype none
module jkv_cfg (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [jkv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [jkv_pkg::CFG_DATA_W-1:0]     cfg_data,
  output jkv_pkg::key_cfg_t                  key
);

  logic [jkv_pkg::KEY_BITS-1:0]  key_bytes_r;
  logic [jkv_pkg::KEY_LEN_W-1:0] key_length_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r  <= '0;
      key_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jkv_pkg::REG_KEY_BYTES:  key_bytes_r  <= cfg_data[jkv_pkg::KEY_BITS-1:0];
        jkv_pkg::REG_KEY_LENGTH: key_length_r <= cfg_data[jkv_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign key.key_bytes  = key_bytes_r;
  assign key.key_length = key_length_r;

endmodule
`default_nettype wire

// ----- hw/rtl/jkv_scan.sv -----
// Per-byte scanner: key match, colon search, value delimiting and result.
// Depends on jkv_pkg and json_key_value_extractor_assert.svh.
`default_nettype none
`include "json_key_value_extractor_assert.svh"
module jkv_scan (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step,
  input  wire jkv_pkg::in_t      item,
  input  wire jkv_pkg::key_cfg_t key,
  output jkv_pkg::scan_res_t    result
);

  localparam logic [2:0] PH_SEARCH    = 3'd0;
  localparam logic [2:0] PH_KEY       = 3'd1;
  localparam logic [2:0] PH_PRECOLON  = 3'd2;
  localparam logic [2:0] PH_POSTCOLON = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  localparam logic [jkv_pkg::DEPTH_BITS-1:0] DEPTH_MAX = '1;

  logic [2:0]                      phase_r, phase_nxt;
  logic [jkv_pkg::KEY_LEN_W-1:0]   match_r, match_nxt;
  logic [jkv_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [jkv_pkg::POS_W-1:0]       start_r, start_nxt;
  logic [jkv_pkg::POS_W-1:0]       trim_r, trim_nxt;
  logic [jkv_pkg::DEPTH_BITS-1:0]  depth_r, depth_nxt;
  logic                            instr_r, instr_nxt;
  logic                            esc_r, esc_nxt;

  logic                            emit;
  jkv_pkg::out_t                   res;

  always_comb begin
    logic [7:0]                     b;
    logic [jkv_pkg::KEY_LEN_W-1:0]  klen;
    logic [7:0]                     kc;
    logic [jkv_pkg::POS_W-1:0]      pos_inc;
    logic                           srch;
    logic                           val_go;
    logic                           fresh;
    logic                           end_v;
    logic [jkv_pkg::DEPTH_BITS-1:0] depth_c;
    logic                           instr_c;
    logic                           esc_c;
    logic [jkv_pkg::POS_W-1:0]      start_c;
    logic [jkv_pkg::POS_W-1:0]      trim_c;

    b       = item.data_byte;
    klen    = (key.key_length > jkv_pkg::KEY_LEN_W'(jkv_pkg::MAX_KEY_BYTES))
              ? jkv_pkg::KEY_LEN_W'(jkv_pkg::MAX_KEY_BYTES) : key.key_length;
    kc      = key.key_bytes[{match_r[jkv_pkg::KEY_IDX_W-1:0], 3'b000} +: 8];
    pos_inc = pos_r + 1'b1;
    srch    = 1'b0;
    val_go  = 1'b0;
    fresh   = 1'b0;
    end_v   = 1'b0;

    phase_nxt = phase_r;
    match_nxt = match_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    trim_nxt  = trim_r;
    depth_nxt = depth_r;
    instr_nxt = instr_r;
    esc_nxt   = esc_r;
    emit      = 1'b0;
    res       = '0;

    case (phase_r)
      PH_SEARCH: srch = 1'b1;
      PH_KEY: begin
        if (match_r < klen) begin
          if (b == kc) match_nxt = match_r + 1'b1;
          else         srch = 1'b1;
        end else if (b == jkv_pkg::CH_QUOTE) begin
          phase_nxt = PH_PRECOLON;
        end else begin
          srch = 1'b1;
        end
      end
      PH_PRECOLON: begin
        if (b == jkv_pkg::CH_COLON)    phase_nxt = PH_POSTCOLON;
        else if (!jkv_pkg::is_blank(b)) srch = 1'b1;
      end
      PH_POSTCOLON: begin
        if (!jkv_pkg::is_blank(b)) begin
          fresh     = 1'b1;
          val_go    = 1'b1;
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: val_go = 1'b1;
      default: ;
    endcase

    // the breaking byte may itself open a new candidate
    if (srch) begin
      if (b == jkv_pkg::CH_QUOTE) begin
        phase_nxt = PH_KEY;
        match_nxt = '0;
      end else begin
        phase_nxt = PH_SEARCH;
      end
    end

    depth_c = fresh ? '0 : depth_r;
    instr_c = fresh ? 1'b0 : instr_r;
    esc_c   = fresh ? 1'b0 : esc_r;
    start_c = fresh ? pos_r : start_r;
    trim_c  = fresh ? pos_r : trim_r;

    if (val_go) begin
      start_nxt = start_c;
      trim_nxt  = trim_c;
      depth_nxt = depth_c;
      instr_nxt = instr_c;
      esc_nxt   = esc_c;
      if (!instr_c) begin
        if (b == jkv_pkg::CH_QUOTE) begin
          instr_nxt = 1'b1;
        end else if (b inside {jkv_pkg::CH_LBRACE, jkv_pkg::CH_LBRACKET}) begin
          if (depth_c != DEPTH_MAX) depth_nxt = depth_c + 1'b1;
        end else if (b inside {jkv_pkg::CH_RBRACE, jkv_pkg::CH_RBRACKET}) begin
          if (depth_c == '0) end_v = 1'b1;
          else               depth_nxt = depth_c - 1'b1;
        end else if (b == jkv_pkg::CH_COMMA && depth_c == '0) begin
          end_v = 1'b1;
        end
      end else if (esc_c) begin
        esc_nxt = 1'b0;
      end else if (b == jkv_pkg::CH_BACKSLASH) begin
        esc_nxt = 1'b1;
      end else if (b == jkv_pkg::CH_QUOTE) begin
        instr_nxt = 1'b0;
      end

      if (end_v) begin
        emit             = 1'b1;
        res.found        = 1'b1;
        res.value_start  = start_c;
        res.value_length = trim_c - start_c;
        phase_nxt        = PH_DONE;
      end else if (!jkv_pkg::is_blank(b)) begin
        trim_nxt = pos_inc;
      end
    end

    if (item.last_byte) begin
      if (!emit && phase_nxt != PH_DONE) begin
        emit = 1'b1;
        if (phase_nxt == PH_POSTCOLON) begin
          res.found        = 1'b1;
          res.value_start  = pos_inc;
          res.value_length = '0;
        end else if (phase_nxt == PH_VALUE) begin
          res.found        = 1'b1;
          res.value_start  = start_nxt;
          res.value_length = trim_nxt - start_nxt;
        end
      end
      phase_nxt = PH_SEARCH;
      match_nxt = '0;
      pos_nxt   = '0;
      start_nxt = '0;
      trim_nxt  = '0;
      depth_nxt = '0;
      instr_nxt = 1'b0;
      esc_nxt   = 1'b0;
    end else begin
      pos_nxt = pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      match_r <= '0;
      pos_r   <= '0;
      start_r <= '0;
      trim_r  <= '0;
      depth_r <= '0;
      instr_r <= 1'b0;
      esc_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      trim_r  <= trim_nxt;
      depth_r <= depth_nxt;
      instr_r <= instr_nxt;
      esc_r   <= esc_nxt;
    end
  end

  assign result.emit = emit;
  assign result.res  = res;

  // an escape is only ever pending inside a string
  `JKV_ASSERT_SAME(a_esc_in_string, esc_r, instr_r)
  `JKV_ASSERT_NEXT(a_pos_cleared, step && item.last_byte, pos_r == '0)
  `JKV_ASSERT_SAME(a_done_silent, phase_r == PH_DONE, !emit)

endmodule
`default_nettype wire

// ----- hw/rtl/json_key_value_extractor.sv -----
// JSON key/value extractor
//
// Input channel (in_valid/in_ready/in_data): one text byte per transaction,
// with last_byte marking the final byte of a text. Result channel
// (out_valid/out_ready/out_data): at most one transaction per text giving
// found, value_start and value_length. Configuration channel
// (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes the 64-bit key
// characters, index 1 the key length; always ready, and meant to be written
// between texts.
//
// Throughput is one byte per cycle unless a result stalls: a byte goes from
// the input register through the scanner's state update. A result is
// registered in the output register when the scanner steps on its byte.
// If the receiver stalls with a result pending, bytes that produce no result
// keep flowing; a byte that would produce a second result waits in the input
// register, and in_ready drops until out_ready frees the output register.
// Reset (rst_n low, synchronous) clears both valid flags, the scan state and
// the key configuration.
// Depends on jkv_pkg, jkv_cfg, jkv_scan and json_key_value_extractor_assert.svh.
`default_nettype none
`include "json_key_value_extractor_assert.svh"
module json_key_value_extractor (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire jkv_pkg::in_t                 in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output jkv_pkg::out_t                     out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [jkv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [jkv_pkg::CFG_DATA_W-1:0]    cfg_data
);

  jkv_pkg::in_t       in_r;
  logic               in_valid_r;
  jkv_pkg::out_t      out_r;
  logic               out_valid_r;
  jkv_pkg::key_cfg_t  key;
  jkv_pkg::scan_res_t scan_res;
  logic               adv;

  jkv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  jkv_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .item   (in_r),
    .key    (key),
    .result (scan_res)
  );

  // the held byte proceeds unless its result would hit a full, stalled output
  assign adv      = in_valid_r && (!scan_res.emit || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && scan_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && scan_res.emit) begin
      out_r <= scan_res.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `JKV_ASSERT_NEXT(a_result_lands, adv && scan_res.emit, out_valid_r)
  `JKV_ASSERT_SAME(a_no_overwrite, in_valid_r && scan_res.emit && out_valid_r && !out_ready, !in_ready)
  `JKV_ASSERT_SAME(a_miss_zeroed, out_valid_r && !out_r.found, out_r.value_start == '0 && out_r.value_length == '0)

endmodule
`default_nettype wire

// ----- tb/json_key_value_extractor_test.sv -----
// Self-checking bench for json_key_value_extractor: streams JSON-like texts byte by byte,
// predicts each key/value result in a scoreboard class and compares every output transaction.
// Depends on jkv_pkg and the json_key_value_extractor RTL.
`default_nettype none
module json_key_value_extractor_test;
  import jkv_pkg::*;

  typedef enum logic [2:0] {
    SEEK_QUOTE, MATCH_KEY, AWAIT_COLON, SKIP_BLANKS, IN_VALUE, TEXT_DONE
  } scan_phase_t;

  class kv_scoreboard;
    logic [KEY_BITS-1:0]   key;
    logic [KEY_LEN_W-1:0]  key_len;
    scan_phase_t           phase;
    logic [3:0]            midx;
    logic [POS_W-1:0]      pos, vstart, vend;
    logic [DEPTH_BITS-1:0] depth;
    bit                    in_str, esc;
    out_t                  located_q[$];
    int                    errors;

    function new();
      key = '0;
      key_len = '0;
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      phase = SEEK_QUOTE;
      midx = '0;
      pos = '0;
      vstart = '0;
      vend = '0;
      depth = '0;
      in_str = 0;
      esc = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_KEY_BYTES) key = d;
      else if (idx == REG_KEY_LENGTH) key_len = d[KEY_LEN_W-1:0];
    endfunction

    function bit blank(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function void seek(logic [7:0] b);
      if (b == CH_QUOTE) begin
        phase = MATCH_KEY;
        midx = '0;
      end else begin
        phase = SEEK_QUOTE;
      end
    endfunction

    // true when b terminates the value
    function bit value_ends(logic [7:0] b, logic [POS_W-1:0] p);
      if (!in_str) begin
        if (b == CH_QUOTE) in_str = 1;
        else if (b == CH_LBRACE || b == CH_LBRACKET) begin
          if (depth != '1) depth++;
        end else if (b == CH_RBRACE || b == CH_RBRACKET) begin
          if (depth == 0) return 1;
          depth--;
        end else if (b == CH_COMMA && depth == 0) return 1;
      end else if (esc) esc = 0;
      else if (b == CH_BACKSLASH) esc = 1;
      else if (b == CH_QUOTE) in_str = 0;
      if (!blank(b)) vend = p + 1;
      return 0;
    endfunction

    function void note_byte(in_t it);
      logic [7:0]       b;
      logic [POS_W-1:0] p;
      int               klen;
      bit               emit, run_value;
      out_t             r;
      b = it.data_byte;
      p = pos;
      klen = (key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len;
      emit = 0;
      run_value = 0;
      r = '0;
      case (phase)
        SEEK_QUOTE: seek(b);
        MATCH_KEY: begin
          if (midx < klen) begin
            if (b == key[8*midx +: 8]) midx++;
            else seek(b);
          end else if (b == CH_QUOTE) phase = AWAIT_COLON;
          else seek(b);
        end
        AWAIT_COLON: begin
          if (b == CH_COLON) phase = SKIP_BLANKS;
          else if (!blank(b)) seek(b);
        end
        SKIP_BLANKS: begin
          if (!blank(b)) begin
            phase = IN_VALUE;
            vstart = p;
            vend = p;
            depth = '0;
            in_str = 0;
            esc = 0;
            run_value = 1;
          end
        end
        IN_VALUE: run_value = 1;
        default: ;
      endcase
      if (run_value && value_ends(b, p)) begin
        emit = 1;
        r.found = 1'b1;
        r.value_start = vstart;
        r.value_length = vend - vstart;
        phase = TEXT_DONE;
      end
      if (it.last_byte) begin
        if (!emit && phase != TEXT_DONE) begin
          emit = 1;
          if (phase == SKIP_BLANKS) begin
            r.found = 1'b1;
            r.value_start = p + 1;
          end else if (phase == IN_VALUE) begin
            r.found = 1'b1;
            r.value_start = vstart;
            r.value_length = vend - vstart;
          end
        end
        clear_scan();
      end else begin
        pos = p + 1;
      end
      if (emit) located_q.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check(out_t got);
      out_t want;
      if (located_q.size() == 0) begin
        report($sformatf("unexpected result found=%0d start=%0d len=%0d",
                         got.found, got.value_start, got.value_length));
        return;
      end
      want = located_q.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %0d, want %0d", got.found, want.found));
      if (got.value_start !== want.value_start)
        report($sformatf("value_start %0d, want %0d", got.value_start, want.value_start));
      if (got.value_length !== want.value_length)
        report($sformatf("value_length %0d, want %0d", got.value_length, want.value_length));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid, in_ready;
  in_t                   in_data;
  logic                  out_valid, out_ready;
  out_t                  out_data;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kv_scoreboard          sb;
  int                    n_in = 0;
  bit                    held_once = 0;
  logic [KEY_BITS-1:0]   cur_key;
  logic [KEY_LEN_W-1:0]  cur_len;

  json_key_value_extractor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling at all in this window of the run
  function automatic bit calm();
    return n_in >= 600 && n_in < 850;
  endfunction

  function automatic void push_str(ref logic [7:0] t[$], input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  function automatic void add_blanks(ref logic [7:0] t[$], input int most);
    int n;
    n = $urandom_range(most);
    repeat (n) begin
      case ($urandom_range(3))
        0: t.push_back(CH_SPACE);
        1: t.push_back(CH_TAB);
        2: t.push_back(CH_CR);
        default: t.push_back(CH_LF);
      endcase
    end
  endfunction

  // quoted key: exact, or a near miss (prefix, flipped bit, extra char)
  function automatic void add_key(ref logic [7:0] t[$], input bit exact);
    int         klen, n, k;
    logic [7:0] c;
    klen = (cur_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : cur_len;
    t.push_back(CH_QUOTE);
    if (exact) begin
      for (int i = 0; i < klen; i++) t.push_back(cur_key[8*i +: 8]);
    end else begin
      case ($urandom_range(2))
        0: begin
          n = $urandom_range(klen);
          for (int i = 0; i < n; i++) t.push_back(cur_key[8*i +: 8]);
        end
        1: begin
          k = (klen == 0) ? 0 : $urandom_range(klen - 1);
          for (int i = 0; i < klen; i++) begin
            c = cur_key[8*i +: 8];
            if (i == k) c = c ^ (8'h01 << $urandom_range(7));
            t.push_back(c);
          end
          if (klen == 0) t.push_back(8'h61 + 8'($urandom_range(25)));
        end
        default: begin
          for (int i = 0; i < klen; i++) t.push_back(cur_key[8*i +: 8]);
          t.push_back(8'h61 + 8'($urandom_range(25)));
        end
      endcase
    end
    t.push_back(CH_QUOTE);
  endfunction

  function automatic void add_value(ref logic [7:0] t[$], input int nest);
    int n;
    case ($urandom_range(nest > 0 ? 5 : 3))
      0: begin
        if ($urandom_range(3) == 0) t.push_back(8'h2d);
        n = $urandom_range(1, 4);
        repeat (n) t.push_back(8'h30 + 8'($urandom_range(9)));
      end
      1: begin
        if ($urandom_range(1)) push_str(t, "true");
        else push_str(t, "null");
      end
      2, 3: begin
        t.push_back(CH_QUOTE);
        n = $urandom_range(6);
        repeat (n) begin
          case ($urandom_range(5))
            0: begin
              t.push_back(CH_BACKSLASH);
              t.push_back($urandom_range(1) ? CH_QUOTE : CH_BACKSLASH);
            end
            1: t.push_back($urandom_range(1) ? CH_COMMA : CH_RBRACE);
            2: t.push_back($urandom_range(1) ? CH_LBRACKET : CH_COLON);
            3: t.push_back(CH_SPACE);
            default: t.push_back(8'h61 + 8'($urandom_range(25)));
          endcase
        end
        t.push_back(CH_QUOTE);
      end
      4: begin
        t.push_back(CH_LBRACE);
        n = $urandom_range(2);
        for (int i = 0; i < n; i++) begin
          if (i > 0) t.push_back(CH_COMMA);
          add_key(t, 0);
          t.push_back(CH_COLON);
          add_blanks(t, 1);
          add_value(t, nest - 1);
        end
        t.push_back(CH_RBRACE);
      end
      default: begin
        t.push_back(CH_LBRACKET);
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) t.push_back(CH_COMMA);
          add_blanks(t, 1);
          add_value(t, nest - 1);
        end
        t.push_back(CH_RBRACKET);
      end
    endcase
  endfunction

  function automatic void build_text(ref logic [7:0] t[$]);
    int n;
    if ($urandom_range(99) < 12) begin
      // noise
      n = $urandom_range(1, 24);
      repeat (n) begin
        case ($urandom_range(4))
          0: t.push_back(CH_QUOTE);
          1: t.push_back($urandom_range(1) ? CH_COLON : CH_COMMA);
          2: t.push_back(cur_key[8*$urandom_range(7) +: 8]);
          default: t.push_back(8'($urandom()));
        endcase
      end
      return;
    end
    if ($urandom_range(1)) t.push_back(CH_LBRACE);
    add_blanks(t, 2);
    n = $urandom_range(2);
    repeat (n) begin
      add_key(t, 0);
      add_blanks(t, 1);
      t.push_back(CH_COLON);
      add_blanks(t, 1);
      add_value(t, 1);
      t.push_back(CH_COMMA);
      add_blanks(t, 1);
    end
    add_key(t, 1);
    add_blanks(t, 2);
    if ($urandom_range(9) != 0) t.push_back(CH_COLON);
    add_blanks(t, 2);
    if ($urandom_range(9) != 0) begin
      add_value(t, 2);
      add_blanks(t, 2);
      case ($urandom_range(3))
        0: t.push_back(CH_COMMA);
        1: t.push_back(CH_RBRACE);
        2: t.push_back(CH_RBRACKET);
        default: ;
      endcase
      n = $urandom_range(4);
      repeat (n) t.push_back(8'($urandom_range(32, 126)));
    end
    // broken text: cut short anywhere
    if ($urandom_range(6) == 0) begin
      n = $urandom_range(1, t.size());
      while (t.size() > n) void'(t.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_t item;
    bit  took;
    if (!calm() && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    item.data_byte = b;
    item.last_byte = fin;
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sb.note_byte(item);
    n_in++;
  endtask

  task automatic send_text(ref logic [7:0] t[$]);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1);
  endtask

  // drain: nothing outstanding, then let trailing bytes clear the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.located_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_key(input logic [CFG_DATA_W-1:0] kb, input logic [CFG_DATA_W-1:0] kw);
    bit took;
    for (int r = 0; r < 2; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? REG_KEY_BYTES : REG_KEY_LENGTH;
      cfg_data <= (r == 0) ? kb : kw;
      do begin
        @(negedge clk);
        took = cfg_ready;
        @(posedge clk);
      end while (!took);
      sb.set_reg((r == 0) ? REG_KEY_BYTES : REG_KEY_LENGTH, (r == 0) ? kb : kw);
    end
    cfg_valid <= 1'b0;
    cur_key = kb;
    cur_len = kw[KEY_LEN_W-1:0];
  endtask

  initial begin
    logic [7:0]            t[$];
    logic [CFG_DATA_W-1:0] kb, kw;
    int                    texts, phase_no;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_KEY_BYTES;
    cfg_data = '0;
    cur_key = '0;
    cur_len = '0;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // key "ab"
    load_key(64'h6261, 64'd2);
    push_str(t, "\"ab\":1,");
    send_text(t);
    t.delete();
    // failed candidate re-opens on its quote; text ends after the colon
    push_str(t, "x\"a\"ab\" :");
    send_text(t);
    t.delete();
    t.push_back(8'h00);
    push_str(t, "\"ab\"");
    t.push_back(8'hff);
    send_text(t);
    t.delete();
    push_str(t, "}");
    send_text(t);

    texts = 0;
    phase_no = 0;
    while (n_in < 1250) begin
      if (texts % 6 == 0) begin
        settle();
        phase_no++;
        for (int i = 0; i < 8; i++) kb[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
        kw = {$urandom(), $urandom()};
        case (phase_no)
          1: begin kb = '1; kw[3:0] = 4'd15; end
          2: begin kb = '0; kw[3:0] = 4'd0; end
          3: kw[3:0] = 4'd8;
          4: begin kb[15:8] = CH_QUOTE; kw[3:0] = 4'd3; end
          default: begin
            if ($urandom_range(3) == 0) kb = {$urandom(), $urandom()};
            kw[3:0] = 4'($urandom_range(15));
          end
        endcase
        load_key(kb, kw);
      end
      t.delete();
      if (texts == 20) begin
        // nesting past saturation, then one closer too many ends the value
        add_key(t, 1);
        t.push_back(CH_COLON);
        t.push_back(CH_SPACE);
        repeat (260) t.push_back($urandom_range(1) ? CH_LBRACKET : CH_LBRACE);
        t.push_back(8'h71);
        repeat (262) t.push_back($urandom_range(1) ? CH_RBRACKET : CH_RBRACE);
      end else begin
        build_text(t);
      end
      send_text(t);
      texts++;
    end
    settle();
    if (sb.errors == 0 && sb.located_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!held_once && n_in >= 300) begin
        held_once = 1;
        hold = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm() || ($urandom_range(99) >= 24);
      end
    end
  end

  // a result transaction completes at the edge after a negedge with both high
  initial begin
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) sb.check(out_data);
    end
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
